// ----- design/hrlp_pkg.sv -----
// shared types, codes and constants for the http request line parser
package hrlp_pkg;

  // input request fields
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  // result fields
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       accepted;
  } result_t;

  // result kinds
  localparam logic [1:0] KIND_METHOD  = 2'd0;
  localparam logic [1:0] KIND_PATH    = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // parse phases
  localparam logic [2:0] PH_METHOD  = 3'd0;
  localparam logic [2:0] PH_PATH    = 3'd1;
  localparam logic [2:0] PH_VERSION = 3'd2;
  localparam logic [2:0] PH_REST    = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_METHOD_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATH_LIMIT   = 2'd1;

  // register reset values
  localparam logic [7:0]  METHOD_LIMIT_RST = 8'd16;
  localparam logic [15:0] PATH_LIMIT_RST   = 16'd1024;

  // characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [2:0] VERSION_LEN = 3'd5;

  // bytes of the version tag "HTTP/"
  function automatic logic [7:0] version_tag(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = 8'h48;
      3'd1: ch = 8'h54;
      3'd2: ch = 8'h54;
      3'd3: ch = 8'h50;
      3'd4: ch = 8'h2F;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- design/hrlp_parse.sv -----
// parse state registers and the per-byte step logic
module hrlp_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  hrlp_pkg::item_t  item,
  input  logic [7:0]       method_limit,
  input  logic [15:0]      path_limit,
  output logic             res_valid,
  output hrlp_pkg::result_t res
);
  import hrlp_pkg::*;

  logic [2:0]  phase;
  logic [7:0]  method_count;
  logic [15:0] path_count;
  logic        in_query;
  logic [2:0]  version_count;
  logic        failed;

  logic [2:0]  phase_next;
  logic [7:0]  method_count_next;
  logic [15:0] path_count_next;
  logic        in_query_next;
  logic [2:0]  version_count_next;
  logic        failed_next;

  logic [7:0]  b;
  logic [7:0]  mc_inc;
  logic [15:0] pc_inc;
  logic [2:0]  vc_inc;
  logic        emit_method;
  logic        emit_path;

  // one step of the parse; a first byte restarts from the cleared state
  always_comb begin
    b                  = item.data_byte;
    phase_next         = item.first_byte ? PH_METHOD : phase;
    method_count_next  = item.first_byte ? 8'd0 : method_count;
    path_count_next    = item.first_byte ? 16'd0 : path_count;
    in_query_next      = item.first_byte ? 1'b0 : in_query;
    version_count_next = item.first_byte ? 3'd0 : version_count;
    failed_next        = item.first_byte ? 1'b0 : failed;
    mc_inc = (method_count_next == 8'hFF) ? method_count_next : method_count_next + 8'd1;
    pc_inc = (path_count_next == 16'hFFFF) ? path_count_next : path_count_next + 16'd1;
    vc_inc = version_count_next + 3'd1;
    emit_method  = 1'b0;
    emit_path    = 1'b0;
    res_valid    = 1'b0;
    res.kind     = KIND_VERDICT;
    res.out_byte = 8'd0;
    res.accepted = 1'b0;

    if (phase_next == PH_DONE) begin
      // verdict already given: ignore until a new buffer
    end else if (b inside {CH_CR, CH_LF}) begin
      res_valid    = 1'b1;
      res.accepted = !failed_next && (phase_next == PH_REST);
      phase_next   = PH_DONE;
    end else begin
      case (phase_next)
        PH_METHOD: begin
          if (b == CH_SPACE) begin
            if (method_count_next == 8'd0) failed_next = 1'b1;
            phase_next = PH_PATH;
          end else begin
            method_count_next = mc_inc;
            if (mc_inc >= method_limit) failed_next = 1'b1;
            emit_method = 1'b1;
          end
        end
        PH_PATH: begin
          if (b == CH_SPACE) begin
            if (path_count_next == 16'd0) failed_next = 1'b1;
            phase_next         = PH_VERSION;
            version_count_next = 3'd0;
          end else if (!in_query_next) begin
            if (b inside {CH_QUERY, CH_HASH}) begin
              in_query_next = 1'b1;
            end else begin
              if (path_count_next == 16'd0 && b != CH_SLASH) failed_next = 1'b1;
              path_count_next = pc_inc;
              if (pc_inc >= path_limit) failed_next = 1'b1;
              emit_path = 1'b1;
            end
          end
        end
        PH_VERSION: begin
          if (version_count_next < VERSION_LEN && b != version_tag(version_count_next))
            failed_next = 1'b1;
          version_count_next = vc_inc;
          if (vc_inc >= VERSION_LEN) phase_next = PH_REST;
        end
        default: begin
        end
      endcase

      // buffer end without terminator rejects in place of a byte result
      if (item.last_byte) begin
        phase_next   = PH_DONE;
        res_valid    = 1'b1;
        res.kind     = KIND_VERDICT;
        res.accepted = 1'b0;
      end else if (emit_method) begin
        res_valid    = 1'b1;
        res.kind     = KIND_METHOD;
        res.out_byte = b;
      end else if (emit_path) begin
        res_valid    = 1'b1;
        res.kind     = KIND_PATH;
        res.out_byte = b;
      end
    end
  end

  // state update on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_METHOD;
      method_count  <= 8'd0;
      path_count    <= 16'd0;
      in_query      <= 1'b0;
      version_count <= 3'd0;
      failed        <= 1'b0;
    end else if (fire) begin
      phase         <= phase_next;
      method_count  <= method_count_next;
      path_count    <= path_count_next;
      in_query      <= in_query_next;
      version_count <= version_count_next;
      failed        <= failed_next;
    end
  end

endmodule

// ----- design/hrlp_out_reg.sv -----
// result register with stall handling
module hrlp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  input  hrlp_pkg::result_t load_data,
  output logic              free,
  output logic              result_valid,
  input  logic              result_stall,
  output hrlp_pkg::result_t result
);
  import hrlp_pkg::*;

  // slot can take a new result when empty or being drained
  assign free = !result_valid || !result_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (free) begin
      result_valid <= load_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (free && load_valid) begin
      result <= load_data;
    end
  end

endmodule

// ----- design/http_request_line_parser.sv -----
// top level of the http request line parser
// an accepted byte is held in the input register, then its result in the result register; result_stall can hold either
// throughput: one byte per cycle while the result register is free; bytes that give no result still take a parse step
// the input register and result register let a new byte in while a result waits
// reset (synchronous, active high) clears both registers' valid flags and the parse state,
// and sets method_limit to 16 and path_limit to 1024
module http_request_line_parser (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  hrlp_pkg::item_t                   item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output hrlp_pkg::result_t                 result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hrlp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                       cfg_data
);
  import hrlp_pkg::*;

  logic [7:0]  method_limit;
  logic [15:0] path_limit;
  logic        item_full;
  item_t       item_q;
  logic        out_free;
  logic        fire;
  logic        res_valid;
  result_t     res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      method_limit <= METHOD_LIMIT_RST;
      path_limit   <= PATH_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_METHOD_LIMIT: method_limit <= cfg_data[7:0];
        CFG_PATH_LIMIT:   path_limit   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register
  assign fire       = item_full && out_free;
  assign item_stall = item_full && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_full <= 1'b1;
    end else if (fire) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_q <= item;
    end
  end

  // parse step
  hrlp_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .item         (item_q),
    .method_limit (method_limit),
    .path_limit   (path_limit),
    .res_valid    (res_valid),
    .res          (res)
  );

  // result register
  hrlp_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (fire && res_valid),
    .load_data    (res),
    .free         (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTHESIS
  // byte results never carry an accept flag
  a_byte_not_accepted: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind != KIND_VERDICT |-> !result.accepted)
    else $error("byte result with accepted set");

  // verdicts carry no byte
  a_verdict_zero_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_VERDICT |-> result.out_byte == 8'd0)
    else $error("verdict with non-zero byte");

  // right after reset no result is valid and the input is not stalled
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("output or input busy after reset");
`endif

endmodule
